[rtl/gpio_rb_pkg.sv]
package gpio_rb_pkg;

  localparam int NUM_PINS_DEF  = 54;
  localparam int PIN_W         = 54;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 4;
  localparam int WIDE_W        = 64;
  localparam int FSEL_WORDS    = 6;
  localparam int PINS_PER_WORD = 10;
  localparam int FIELD_W       = 3;
  localparam int FSEL_W        = PINS_PER_WORD * FIELD_W;
  localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);
  localparam int PULL_W        = 2;

  localparam logic [IDX_W-1:0] REG_FSEL0    = 4'd0;
  localparam logic [IDX_W-1:0] REG_FSEL5    = 4'd5;
  localparam logic [IDX_W-1:0] REG_SET0     = 4'd6;
  localparam logic [IDX_W-1:0] REG_SET1     = 4'd7;
  localparam logic [IDX_W-1:0] REG_CLR0     = 4'd8;
  localparam logic [IDX_W-1:0] REG_CLR1     = 4'd9;
  localparam logic [IDX_W-1:0] REG_LEV0     = 4'd10;
  localparam logic [IDX_W-1:0] REG_LEV1     = 4'd11;
  localparam logic [IDX_W-1:0] REG_PULL     = 4'd12;
  localparam logic [IDX_W-1:0] REG_PULLCLK0 = 4'd13;
  localparam logic [IDX_W-1:0] REG_PULLCLK1 = 4'd14;

  localparam logic [PULL_W-1:0] PULL_OFF  = 2'd0;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

  localparam logic [FIELD_W-1:0] FSEL_OUTPUT = 3'd1;

  typedef struct packed {
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic [PIN_W-1:0]  level;
  } access_t;

  // fsel bits of word w that belong to existing pins
  function automatic logic [FSEL_W-1:0] fsel_valid_mask(logic [FSEL_IDX_W-1:0] w,
                                                        int num_pins);
    logic [FSEL_W-1:0] m;
    m = '0;
    for (int k = 0; k < PINS_PER_WORD; k++) begin
      if (int'(w) * PINS_PER_WORD + k < num_pins) begin
        m[k*FIELD_W +: FIELD_W] = '1;
      end
    end
    return m;
  endfunction

endpackage

[rtl/gpio_rb_state.sv]
module gpio_rb_state #(
  parameter int NUM_PINS = gpio_rb_pkg::NUM_PINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                acc_en,
  input  gpio_rb_pkg::access_t                acc,
  output logic [gpio_rb_pkg::DATA_W-1:0]      read_data,
  output logic [gpio_rb_pkg::PIN_W-1:0]       pin_out_level,
  output logic [gpio_rb_pkg::PIN_W-1:0]       pin_out_enable,
  output logic [gpio_rb_pkg::PIN_W-1:0]       pull_up_enable,
  output logic [gpio_rb_pkg::PIN_W-1:0]       pull_down_enable
);

  localparam int WIDE_W = gpio_rb_pkg::WIDE_W;
  localparam int DATA_W = gpio_rb_pkg::DATA_W;
  localparam int FSEL_W = gpio_rb_pkg::FSEL_W;

  logic [FSEL_W-1:0]               fsel [gpio_rb_pkg::FSEL_WORDS];
  logic [NUM_PINS-1:0]             out_latch, out_latch_next;
  logic [NUM_PINS-1:0]             pull_up, pull_up_next;
  logic [NUM_PINS-1:0]             pull_dn, pull_dn_next;
  logic [gpio_rb_pkg::PULL_W-1:0]  pull_ctl, pull_ctl_next;
  logic [NUM_PINS-1:0]             oe;

  logic [WIDE_W-1:0]               pin_mask_w;
  logic [WIDE_W-1:0]               level_w;
  logic [WIDE_W-1:0]               sel_w;
  logic [NUM_PINS-1:0]             sel;
  logic                            hi_bank;
  logic                            fsel_hit;
  logic [gpio_rb_pkg::FSEL_IDX_W-1:0] fsel_idx;

  logic [WIDE_W-1:0] latch_w, oe_w, up_w, dn_w;

  assign pin_mask_w = WIDE_W'({NUM_PINS{1'b1}});
  assign level_w    = WIDE_W'(acc.level) & pin_mask_w;
  assign hi_bank    = (acc.idx == gpio_rb_pkg::REG_SET1) ||
                      (acc.idx == gpio_rb_pkg::REG_CLR1) ||
                      (acc.idx == gpio_rb_pkg::REG_PULLCLK1);
  assign sel_w      = hi_bank ? {acc.data, {DATA_W{1'b0}}} : WIDE_W'(acc.data);
  assign sel        = sel_w[NUM_PINS-1:0];
  assign fsel_hit   = (acc.idx <= gpio_rb_pkg::REG_FSEL5);
  assign fsel_idx   = acc.idx[gpio_rb_pkg::FSEL_IDX_W-1:0];

  always_comb begin
    out_latch_next = out_latch;
    pull_up_next   = pull_up;
    pull_dn_next   = pull_dn;
    pull_ctl_next  = pull_ctl;
    read_data      = '0;
    if (acc.wr) begin
      unique case (acc.idx) inside
        gpio_rb_pkg::REG_SET0, gpio_rb_pkg::REG_SET1: begin
          out_latch_next = out_latch | sel;
        end
        gpio_rb_pkg::REG_CLR0, gpio_rb_pkg::REG_CLR1: begin
          out_latch_next = out_latch & ~sel;
        end
        gpio_rb_pkg::REG_PULL: begin
          pull_ctl_next = acc.data[gpio_rb_pkg::PULL_W-1:0];
        end
        gpio_rb_pkg::REG_PULLCLK0, gpio_rb_pkg::REG_PULLCLK1: begin
          case (pull_ctl)
            gpio_rb_pkg::PULL_OFF: begin
              pull_up_next = pull_up & ~sel;
              pull_dn_next = pull_dn & ~sel;
            end
            gpio_rb_pkg::PULL_DOWN: begin
              pull_up_next = pull_up & ~sel;
              pull_dn_next = pull_dn | sel;
            end
            gpio_rb_pkg::PULL_UP: begin
              pull_up_next = pull_up | sel;
              pull_dn_next = pull_dn & ~sel;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end else begin
      unique case (acc.idx) inside
        [gpio_rb_pkg::REG_FSEL0:gpio_rb_pkg::REG_FSEL5]: begin
          read_data = DATA_W'(fsel[fsel_idx]);
        end
        gpio_rb_pkg::REG_LEV0: read_data = level_w[DATA_W-1:0];
        gpio_rb_pkg::REG_LEV1: read_data = level_w[WIDE_W-1:DATA_W];
        gpio_rb_pkg::REG_PULL: read_data = DATA_W'(pull_ctl);
        default:               read_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gpio_rb_pkg::FSEL_WORDS; i++) begin
        fsel[i] <= '0;
      end
      out_latch <= '0;
      pull_up   <= '0;
      pull_dn   <= '0;
      pull_ctl  <= gpio_rb_pkg::PULL_OFF;
    end else if (acc_en) begin
      if (acc.wr && fsel_hit) begin
        fsel[fsel_idx] <= acc.data[FSEL_W-1:0] &
                          gpio_rb_pkg::fsel_valid_mask(fsel_idx, NUM_PINS);
      end
      out_latch <= out_latch_next;
      pull_up   <= pull_up_next;
      pull_dn   <= pull_dn_next;
      pull_ctl  <= pull_ctl_next;
    end
  end

  // output enable per pin from its fsel field
  for (genvar p = 0; p < NUM_PINS; p++) begin : g_oe
    assign oe[p] = (fsel[p / gpio_rb_pkg::PINS_PER_WORD]
                        [(p % gpio_rb_pkg::PINS_PER_WORD) * gpio_rb_pkg::FIELD_W +:
                         gpio_rb_pkg::FIELD_W] == gpio_rb_pkg::FSEL_OUTPUT);
  end

  assign latch_w = WIDE_W'(out_latch);
  assign oe_w    = WIDE_W'(oe);
  assign up_w    = WIDE_W'(pull_up);
  assign dn_w    = WIDE_W'(pull_dn);

  assign pin_out_level    = latch_w[gpio_rb_pkg::PIN_W-1:0];
  assign pin_out_enable   = oe_w[gpio_rb_pkg::PIN_W-1:0];
  assign pull_up_enable   = up_w[gpio_rb_pkg::PIN_W-1:0];
  assign pull_down_enable = dn_w[gpio_rb_pkg::PIN_W-1:0];

endmodule

[rtl/gpio_register_block_core.sv]
// gpio register block: one register access per input transaction
// input channel s_axis: tuser is the access kind (0 read, 1 write), tdata holds
//   the register index, the write data and the sampled pin levels
// output channel m_axis: one result transaction per access, carrying the read
//   value (zero for writes) and the pin drive, enable and pull vectors as they
//   stand after the access
// path: an accepted access waits in the input register, then moves into the result
//   register, where the result becomes valid; a stall can hold it in the input register
// throughput: one access per cycle while the receiver does not stall, set by the
//   single pass from the input register through the register update into the result register
// the input register keeps taking transactions while a result waits, as long
//   as the result register frees up in the same cycle
// when the receiver stalls, the result holds and the input register fills,
//   after which s_axis_tready drops; register state changes only when an
//   access moves into the result register
// reset clears the state registers to zero: every pin an input, latches and pulls
//   off, and it empties both channels
module gpio_register_block_core #(
  parameter int NUM_PINS = gpio_rb_pkg::NUM_PINS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // reg_index, write_data, pin_in_level, zero pad
  input  logic         s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [247:0] m_axis_tdata   // read_data, pin_out_level, pin_out_enable,
                                      // pull_up_enable, pull_down_enable
);

  localparam int IDX_LO  = 0;
  localparam int DATA_LO = IDX_LO + gpio_rb_pkg::IDX_W;
  localparam int LVL_LO  = DATA_LO + gpio_rb_pkg::DATA_W;

  logic                              in_valid;
  gpio_rb_pkg::access_t              in_acc;
  logic                              out_valid;
  logic [gpio_rb_pkg::DATA_W-1:0]    out_rd;
  logic                              advance;

  logic [gpio_rb_pkg::DATA_W-1:0]    rd_next;
  logic [gpio_rb_pkg::PIN_W-1:0]     lvl, oe, up, dn;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_acc.wr    <= s_axis_tuser;
      in_acc.idx   <= s_axis_tdata[DATA_LO-1:IDX_LO];
      in_acc.data  <= s_axis_tdata[LVL_LO-1:DATA_LO];
      in_acc.level <= s_axis_tdata[LVL_LO+gpio_rb_pkg::PIN_W-1:LVL_LO];
    end
  end

  gpio_rb_state #(
    .NUM_PINS (NUM_PINS)
  ) u_state (
    .clk              (clk),
    .rst              (rst),
    .acc_en           (advance),
    .acc              (in_acc),
    .read_data        (rd_next),
    .pin_out_level    (lvl),
    .pin_out_enable   (oe),
    .pull_up_enable   (up),
    .pull_down_enable (dn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rd <= rd_next;
    end
  end

  // register state only moves with the result, so it matches the held result
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {dn, up, oe, lvl, out_rd};

endmodule

[rtl/gpio_rb_checker.sv]
module gpio_rb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [247:0] m_axis_tdata
);

  logic [53:0] up_bits;
  logic [53:0] dn_bits;

  assign up_bits = m_axis_tdata[193:140];
  assign dn_bits = m_axis_tdata[247:194];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
      !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register empty");

  a_pull_exclusive: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (up_bits & dn_bits) == 54'd0)
    else $error("pull-up and pull-down both latched on a pin");

endmodule

bind gpio_register_block_core gpio_rb_checker u_gpio_rb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/testbench.sv]
module testbench;

  localparam int IDX_W  = gpio_rb_pkg::IDX_W;
  localparam int PIN_W  = gpio_rb_pkg::PIN_W;
  localparam int DATA_W = gpio_rb_pkg::DATA_W;
  localparam int FSEL_W = gpio_rb_pkg::FSEL_W;
  localparam int PULL_W = gpio_rb_pkg::PULL_W;
  localparam int FSEL_IDX_W    = gpio_rb_pkg::FSEL_IDX_W;
  localparam int PINS_PER_WORD = gpio_rb_pkg::PINS_PER_WORD;
  localparam int FIELD_W       = gpio_rb_pkg::FIELD_W;

  localparam logic [IDX_W-1:0] REG_UNUSED = 4'd15;
  localparam int ITEMS = 1600;

  typedef struct packed {
    logic [PIN_W-1:0]  pull_down;
    logic [PIN_W-1:0]  pull_up;
    logic [PIN_W-1:0]  out_enable;
    logic [PIN_W-1:0]  out_level;
    logic [DATA_W-1:0] read_data;
  } gpio_result_t;

  class gpio_shadow;
    logic [FSEL_W-1:0] fsel [gpio_rb_pkg::FSEL_WORDS];
    logic [PIN_W-1:0]  out_latch;
    logic [PIN_W-1:0]  up_latch;
    logic [PIN_W-1:0]  down_latch;
    logic [PULL_W-1:0] pull_code;
    gpio_result_t      due[$];
    int                errors;

    function new();
      foreach (fsel[i]) fsel[i] = '0;
      out_latch  = '0;
      up_latch   = '0;
      down_latch = '0;
      pull_code  = gpio_rb_pkg::PULL_OFF;
      errors     = 0;
    endfunction

    function void note_access(logic wr, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data,
                              logic [PIN_W-1:0] level);
      logic [63:0]           wide;
      logic [PIN_W-1:0]      sel;
      logic [FSEL_W-1:0]     keep;
      logic [FSEL_IDX_W-1:0] word;
      gpio_result_t          r;
      // high word of a bank pair covers pins 32 and up
      if (idx == gpio_rb_pkg::REG_SET1 || idx == gpio_rb_pkg::REG_CLR1 ||
          idx == gpio_rb_pkg::REG_PULLCLK1)
        wide = {data, 32'h0};
      else
        wide = {32'h0, data};
      sel = wide[PIN_W-1:0];
      word = idx[FSEL_IDX_W-1:0];
      r = '0;
      if (wr) begin
        if (idx <= gpio_rb_pkg::REG_FSEL5) begin
          keep = '0;
          for (int k = 0; k < PINS_PER_WORD; k++)
            if (int'(idx) * PINS_PER_WORD + k < PIN_W) keep[k*FIELD_W +: FIELD_W] = '1;
          fsel[word] = data[FSEL_W-1:0] & keep;
        end else begin
          case (idx)
            gpio_rb_pkg::REG_SET0, gpio_rb_pkg::REG_SET1: out_latch |= sel;
            gpio_rb_pkg::REG_CLR0, gpio_rb_pkg::REG_CLR1: out_latch &= ~sel;
            gpio_rb_pkg::REG_PULL: pull_code = data[PULL_W-1:0];
            gpio_rb_pkg::REG_PULLCLK0, gpio_rb_pkg::REG_PULLCLK1: begin
              case (pull_code)
                gpio_rb_pkg::PULL_OFF: begin
                  up_latch   &= ~sel;
                  down_latch &= ~sel;
                end
                gpio_rb_pkg::PULL_DOWN: begin
                  up_latch   &= ~sel;
                  down_latch |= sel;
                end
                gpio_rb_pkg::PULL_UP: begin
                  up_latch   |= sel;
                  down_latch &= ~sel;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end else begin
        if (idx <= gpio_rb_pkg::REG_FSEL5) r.read_data = DATA_W'(fsel[word]);
        else if (idx == gpio_rb_pkg::REG_LEV0) r.read_data = level[31:0];
        else if (idx == gpio_rb_pkg::REG_LEV1) r.read_data = DATA_W'(level[PIN_W-1:32]);
        else if (idx == gpio_rb_pkg::REG_PULL) r.read_data = DATA_W'(pull_code);
      end
      r.out_level  = out_latch;
      r.pull_up    = up_latch;
      r.pull_down  = down_latch;
      for (int p = 0; p < PIN_W; p++)
        if (fsel[p / PINS_PER_WORD][(p % PINS_PER_WORD) * FIELD_W +: FIELD_W] ==
            gpio_rb_pkg::FSEL_OUTPUT)
          r.out_enable[p] = 1'b1;
      due.push_back(r);
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(gpio_result_t got);
      gpio_result_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      field_check("read_data", 64'(want.read_data), 64'(got.read_data));
      field_check("pin_out_level", 64'(want.out_level), 64'(got.out_level));
      field_check("pin_out_enable", 64'(want.out_enable), 64'(got.out_enable));
      field_check("pull_up_enable", 64'(want.pull_up), 64'(got.pull_up));
      field_check("pull_down_enable", 64'(want.pull_down), 64'(got.pull_down));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;  // reg_index, write_data, pin_in_level, zero pad
  logic         s_axis_tuser = 1'b0;  // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [247:0] m_axis_tdata;  // read_data, pin_out_level, pin_out_enable,
                               // pull_up_enable, pull_down_enable

  gpio_shadow mirror = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  gpio_register_block_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_access(input logic wr, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data, input logic [PIN_W-1:0] level);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= wr;
    s_axis_tdata  <= {6'b0, level, data, idx};
    do @(posedge clk); while (!s_axis_tready);
    mirror.note_access(wr, idx, data, level);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (mirror.due.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
  end

  initial begin
    #4000000;
    $display("[gpio_register_block_core] ERROR");
    $finish;
  end

  initial begin
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic [63:0]       lvl;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_access(1'b0, gpio_rb_pkg::REG_FSEL0, 32'h0, '0);
    send_access(1'b1, gpio_rb_pkg::REG_FSEL0, 32'hffff_ffff, '1);
    send_access(1'b0, gpio_rb_pkg::REG_FSEL0, 32'h0, '0);
    send_access(1'b1, gpio_rb_pkg::REG_FSEL5, 32'hffff_ffff, '0);
    send_access(1'b0, gpio_rb_pkg::REG_FSEL5, 32'h0, '1);
    send_access(1'b1, gpio_rb_pkg::REG_FSEL0 + 4'd1, 32'h0924_9249, '0);
    send_access(1'b1, gpio_rb_pkg::REG_FSEL5, 32'hc924_9249, '0);
    send_access(1'b1, gpio_rb_pkg::REG_SET0, 32'hffff_ffff, '0);
    send_access(1'b1, gpio_rb_pkg::REG_SET1, 32'hffff_ffff, '0);
    send_access(1'b0, gpio_rb_pkg::REG_SET0, 32'h0, '1);
    send_access(1'b1, gpio_rb_pkg::REG_CLR0, 32'haaaa_aaaa, '0);
    send_access(1'b1, gpio_rb_pkg::REG_CLR1, 32'hffff_ffff, '0);
    send_access(1'b0, gpio_rb_pkg::REG_CLR1, 32'h0, '1);
    send_access(1'b0, gpio_rb_pkg::REG_LEV0, 32'h0, '1);
    send_access(1'b0, gpio_rb_pkg::REG_LEV1, 32'h0, '1);
    send_access(1'b1, gpio_rb_pkg::REG_LEV1, 32'hffff_ffff, '1);
    send_access(1'b1, gpio_rb_pkg::REG_PULL, 32'hffff_ffff, '0);
    send_access(1'b0, gpio_rb_pkg::REG_PULL, 32'h0, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULLCLK0, 32'hffff_ffff, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULL, {30'h0, gpio_rb_pkg::PULL_DOWN}, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULLCLK0, 32'hffff_ffff, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULL, {30'h0, gpio_rb_pkg::PULL_UP}, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULLCLK1, 32'hffff_ffff, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULL, {30'h0, gpio_rb_pkg::PULL_OFF}, '0);
    send_access(1'b1, gpio_rb_pkg::REG_PULLCLK1, 32'h0000_ffff, '0);
    send_access(1'b0, gpio_rb_pkg::REG_PULLCLK0, 32'h0, '0);
    send_access(1'b0, REG_UNUSED, 32'h0, '1);
    send_access(1'b1, REG_UNUSED, 32'hffff_ffff, '0);

    for (int n = 0; n < ITEMS; n++) begin
      if (n == ITEMS / 3) wait_drained();
      if (n == ITEMS - ITEMS / 5) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      wr  = 1'($urandom_range(0, 1));
      idx = IDX_W'($urandom_range(0, 14));
      lvl = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: data = 32'hffff_ffff;
        1: data = 32'h1 << $urandom_range(0, 31);
        default: data = $urandom;
      endcase
      // fsel writes lean toward the output code so enables toggle
      if (wr && idx <= gpio_rb_pkg::REG_FSEL5 && $urandom_range(0, 1) == 0) begin
        for (int k = 0; k < PINS_PER_WORD; k++)
          data[k*FIELD_W +: FIELD_W] = ($urandom_range(0, 2) == 0) ?
                                       gpio_rb_pkg::FSEL_OUTPUT :
                                       FIELD_W'($urandom_range(0, 7));
      end
      send_access(wr, idx, data, lvl[PIN_W-1:0]);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mirror.due.size() != 0)
      $display("%0t: %0d result transactions never arrived", $time, mirror.due.size());
    if (mirror.errors == 0 && mirror.due.size() == 0) begin
      $display("[gpio_register_block_core] OK");
    end else begin
      $display("[gpio_register_block_core] ERROR");
    end
    $finish;
  end

endmodule
